[rtl/core/rmq_pkg.sv]
// Shared types, constants and step functions for the matrix to quaternion core.
package rmq_pkg;

    localparam int FRAC       = 14;
    localparam int IN_W       = 16;
    localparam int CAND_W     = IN_W + 2;
    localparam int D_W        = IN_W + 1;
    localparam int SQ_RAD_W   = 36;
    localparam int SQ_H       = SQ_RAD_W / 2;
    localparam int SQ_REM_W   = SQ_H + 2;
    localparam int DV_NUM_W   = 32;
    localparam int DV_DEN_W   = 18;
    localparam int DV_Q       = 17;
    localparam int C_W        = 18;
    localparam int SQR_W      = 2 * (C_W - 1);
    localparam int OUT_W      = 16;
    localparam int OUT_LIM    = ((1 << FRAC) > 32767) ? 32767 : (1 << FRAC);
    localparam int NSTG       = 1 + SQ_H + 2 + DV_Q + 3 + SQ_H + 2 + DV_Q + 1;

    typedef enum logic [1:0] {
        PICK_W = 2'd0,
        PICK_X = 2'd1,
        PICK_Y = 2'd2,
        PICK_Z = 2'd3
    } t_pick;

    typedef struct packed {
        logic [SQ_RAD_W-1:0] rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_H-1:0]     root;
    } t_sq;

    typedef struct packed {
        logic [3:0][DV_NUM_W-1:0] rem;
        logic [3:0][DV_Q-1:0]     quo;
        logic [DV_DEN_W-1:0]      den;
    } t_dv;

    typedef struct packed {
        t_pick              pick;
        logic [3:0][D_W-1:0] d;
    } t_sb_a;

    typedef struct packed {
        t_pick           pick;
        logic [3:0]      neg;
        logic [SQ_H-1:0] p;
    } t_sb_b;

    // One digit of the restoring square root: bring down two radicand bits.
    function automatic t_sq sqrt_step(t_sq s);
        logic [SQ_REM_W+1:0] acc;
        logic [SQ_REM_W+1:0] trial;
        t_sq r;
        acc   = {s.rem, s.rad[SQ_RAD_W-1 -: 2]};
        trial = (SQ_REM_W + 2)'({s.root, 2'b01});
        r.rad = s.rad << 2;
        if (acc >= trial) begin
            r.rem  = SQ_REM_W'(acc - trial);
            r.root = {s.root[SQ_H-2:0], 1'b1};
        end else begin
            r.rem  = SQ_REM_W'(acc);
            r.root = {s.root[SQ_H-2:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of the restoring division, on all four lanes.
    function automatic t_dv div_step(t_dv s, int b);
        logic [DV_NUM_W+2:0] sh;
        t_dv r;
        r  = s;
        sh = (DV_NUM_W + 3)'(s.den) << b;
        for (int l = 0; l < 4; l++) begin
            if ((DV_NUM_W + 3)'(s.rem[l]) >= sh) begin
                r.rem[l]    = s.rem[l] - sh[DV_NUM_W-1:0];
                r.quo[l][b] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/rmq_sqrt.sv]
// Pipelined integer square root, one result bit per stage, final remainder kept.
module rmq_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rmq_pkg::SQ_RAD_W-1:0] i_rad,
    output logic [rmq_pkg::SQ_H-1:0]     o_root,
    output logic [rmq_pkg::SQ_REM_W-1:0] o_rem
);

    rmq_pkg::t_sq r_st [rmq_pkg::SQ_H];
    rmq_pkg::t_sq n_st [rmq_pkg::SQ_H];
    rmq_pkg::t_sq st_in;

    assign st_in = '{rad: i_rad, rem: '0, root: '0};

    for (genvar k = 0; k < rmq_pkg::SQ_H; k++) begin : g_stage
        always_comb begin
            n_st[k] = rmq_pkg::sqrt_step((k == 0) ? st_in : r_st[(k == 0) ? 0 : k - 1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[rmq_pkg::SQ_H-1].root;
    assign o_rem  = r_st[rmq_pkg::SQ_H-1].rem;

endmodule

[rtl/core/rmq_div4.sv]
// Four-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module rmq_div4 (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [3:0][rmq_pkg::DV_NUM_W-1:0]     i_num,
    input  logic [rmq_pkg::DV_DEN_W-1:0]          i_den,
    output logic [3:0][rmq_pkg::DV_Q-1:0]         o_quo
);

    rmq_pkg::t_dv r_st [rmq_pkg::DV_Q];
    rmq_pkg::t_dv n_st [rmq_pkg::DV_Q];
    rmq_pkg::t_dv st_in;

    assign st_in = '{rem: i_num, quo: '0, den: i_den};

    // stage k resolves the quotient bit of weight DV_Q-1-k
    for (genvar k = 0; k < rmq_pkg::DV_Q; k++) begin : g_stage
        always_comb begin
            n_st[k] = rmq_pkg::div_step((k == 0) ? st_in : r_st[(k == 0) ? 0 : k - 1],
                                        rmq_pkg::DV_Q - 1 - k);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_quo = r_st[rmq_pkg::DV_Q-1].quo;

endmodule

[rtl/core/rotation_matrix_to_quaternion_core.sv]
// Rotation matrix (Q2.14) to unit quaternion (Q2.14), largest-component method, pipelined.
// Stages: two 18-stage square roots, two 17-stage dividers, and nine stages of candidate,
// rounding, dividends, assembly, squaring, summing, clamping and output.
// Throughput: one transaction per cycle; a stall at the output holds every stage.
// Reset (synchronous, active low) clears the stage valid bits only.
module rotation_matrix_to_quaternion_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_m00,
    input  logic [15:0] i_m01,
    input  logic [15:0] i_m02,
    input  logic [15:0] i_m10,
    input  logic [15:0] i_m11,
    input  logic [15:0] i_m12,
    input  logic [15:0] i_m20,
    input  logic [15:0] i_m21,
    input  logic [15:0] i_m22,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_quat_w,
    output logic [15:0] o_quat_x,
    output logic [15:0] o_quat_y,
    output logic [15:0] o_quat_z
);

    localparam int CW  = rmq_pkg::CAND_W;
    localparam int DW  = rmq_pkg::D_W;
    localparam int H   = rmq_pkg::SQ_H;
    localparam int RW  = rmq_pkg::SQ_RAD_W;
    localparam int NW  = rmq_pkg::DV_NUM_W;
    localparam int QW  = rmq_pkg::DV_Q;
    localparam int KW  = rmq_pkg::C_W;
    localparam int F   = rmq_pkg::FRAC;

    logic                        en;
    logic [rmq_pkg::NSTG-1:0]    r_vld;

    assign en      = !r_vld[rmq_pkg::NSTG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[rmq_pkg::NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[rmq_pkg::NSTG-2:0], i_valid};
        end
    end

    // ---- stage 1: candidates, pick, radicand, element sums/differences
    logic signed [CW-1:0] cw, cx, cy, cz, best;
    logic signed [DW-1:0] e12m, e20m, e01m, e01p, e02p, e12p;
    rmq_pkg::t_pick       pk;
    rmq_pkg::t_sb_a       n1_sb, r1_sb;
    logic [RW-1:0]        n1_rad, r1_rad;

    always_comb begin
        cw = CW'($signed(i_m00)) + CW'($signed(i_m11)) + CW'($signed(i_m22));
        cx = CW'($signed(i_m00)) - CW'($signed(i_m11)) - CW'($signed(i_m22));
        cy = CW'($signed(i_m11)) - CW'($signed(i_m00)) - CW'($signed(i_m22));
        cz = CW'($signed(i_m22)) - CW'($signed(i_m00)) - CW'($signed(i_m11));
        pk   = rmq_pkg::PICK_W;
        best = cw;
        if (cx > best) begin
            pk   = rmq_pkg::PICK_X;
            best = cx;
        end
        if (cy > best) begin
            pk   = rmq_pkg::PICK_Y;
            best = cy;
        end
        if (cz > best) begin
            pk   = rmq_pkg::PICK_Z;
            best = cz;
        end
        // the winner is never negative since the candidates sum to zero
        n1_rad = (RW'(best[CW-2:0]) + (RW'(1) << F)) << (F - 2);
        e12m = DW'($signed(i_m12)) - DW'($signed(i_m21));
        e20m = DW'($signed(i_m20)) - DW'($signed(i_m02));
        e01m = DW'($signed(i_m01)) - DW'($signed(i_m10));
        e01p = DW'($signed(i_m01)) + DW'($signed(i_m10));
        e02p = DW'($signed(i_m02)) + DW'($signed(i_m20));
        e12p = DW'($signed(i_m12)) + DW'($signed(i_m21));
        n1_sb.pick = pk;
        n1_sb.d    = '0;
        unique case (pk)
            rmq_pkg::PICK_W: begin
                n1_sb.d[1] = e12m;
                n1_sb.d[2] = e20m;
                n1_sb.d[3] = e01m;
            end
            rmq_pkg::PICK_X: begin
                n1_sb.d[0] = e12m;
                n1_sb.d[2] = e01p;
                n1_sb.d[3] = e02p;
            end
            rmq_pkg::PICK_Y: begin
                n1_sb.d[0] = e20m;
                n1_sb.d[1] = e01p;
                n1_sb.d[3] = e12p;
            end
            default: begin
                n1_sb.d[0] = e01m;
                n1_sb.d[1] = e02p;
                n1_sb.d[2] = e12p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sb  <= n1_sb;
            r1_rad <= n1_rad;
        end
    end

    // ---- picked component: sqrt((max + 1) / 4)
    logic [H-1:0]                  sq1_root;
    logic [rmq_pkg::SQ_REM_W-1:0]  sq1_rem;
    rmq_pkg::t_sb_a                r_sb1 [H];

    rmq_sqrt u_sqrt_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r1_rad),
        .o_root (sq1_root),
        .o_rem  (sq1_rem)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0] <= r1_sb;
            for (int k = 1; k < H; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    // ---- round the root
    logic [H-1:0]   r2_p;
    rmq_pkg::t_sb_a r2_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p  <= sq1_root + H'(rmq_pkg::SQ_REM_W'(sq1_root) < sq1_rem);
            r2_sb <= r_sb1[H-1];
        end
    end

    // ---- dividends for the three other components, divisor 4p
    logic [3:0][NW-1:0]             n3_num, r3_num;
    logic [3:0]                     n3_neg;
    logic [DW-1:0]                  dmag;
    logic [rmq_pkg::DV_DEN_W-1:0]   r3_den;
    rmq_pkg::t_sb_b                 r3_sb;

    always_comb begin
        dmag = '0;
        for (int l = 0; l < 4; l++) begin
            n3_neg[l] = r2_sb.d[l][DW-1];
            dmag      = n3_neg[l] ? DW'(-r2_sb.d[l]) : r2_sb.d[l];
            n3_num[l] = (NW'(dmag) << F) + NW'({r2_p, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num     <= n3_num;
            r3_den     <= rmq_pkg::DV_DEN_W'({r2_p, 2'b00});
            r3_sb.pick <= r2_sb.pick;
            r3_sb.neg  <= n3_neg;
            r3_sb.p    <= r2_p;
        end
    end

    logic [3:0][QW-1:0] dv1_quo;
    rmq_pkg::t_sb_b     r_sb2 [QW];

    rmq_div4 u_div_comp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_num),
        .i_den (r3_den),
        .o_quo (dv1_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0] <= r3_sb;
            for (int k = 1; k < QW; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    // ---- assemble the unnormalised quaternion
    logic [3:0][KW-1:0] n4_c, r4_c, r5_c, r6_c;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (r_sb2[QW-1].pick == rmq_pkg::t_pick'(l)) begin
                n4_c[l] = KW'(r_sb2[QW-1].p);
            end else if (r_sb2[QW-1].neg[l]) begin
                n4_c[l] = KW'(-KW'(dv1_quo[l]));
            end else begin
                n4_c[l] = KW'(dv1_quo[l]);
            end
        end
    end

    // ---- squares, then their sum
    logic [3:0][KW-2:0]                 cmag;
    logic [3:0][rmq_pkg::SQR_W-1:0]     n5_sq, r5_sq;
    logic [RW-1:0]                      r6_sum;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            cmag[l]  = r4_c[l][KW-1] ? (KW-1)'(-r4_c[l]) : r4_c[l][KW-2:0];
            n5_sq[l] = cmag[l] * cmag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c   <= n4_c;
            r5_c   <= r4_c;
            r5_sq  <= n5_sq;
            r6_c   <= r5_c;
            r6_sum <= (RW'(r5_sq[0]) + RW'(r5_sq[1])) + (RW'(r5_sq[2]) + RW'(r5_sq[3]));
        end
    end

    // ---- norm
    logic [H-1:0]                  sq2_root;
    logic [rmq_pkg::SQ_REM_W-1:0]  sq2_rem;
    logic [3:0][KW-1:0]            r_c7 [H];

    rmq_sqrt u_sqrt_n (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r6_sum),
        .o_root (sq2_root),
        .o_rem  (sq2_rem)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c7[0] <= r6_c;
            for (int k = 1; k < H; k++) begin
                r_c7[k] <= r_c7[k-1];
            end
        end
    end

    logic [H-1:0]       r7_n;
    logic [3:0][KW-1:0] r7_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_n <= sq2_root + H'(rmq_pkg::SQ_REM_W'(sq2_root) < sq2_rem);
            r7_c <= r_c7[H-1];
        end
    end

    // ---- normalising dividends
    logic [3:0][NW-1:0]           n8_num, r8_num;
    logic [3:0]                   n8_neg, r8_neg;
    logic [3:0][KW-2:0]           nmag;
    logic [rmq_pkg::DV_DEN_W-1:0] r8_den;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n8_neg[l] = r7_c[l][KW-1];
            nmag[l]   = n8_neg[l] ? (KW-1)'(-r7_c[l]) : r7_c[l][KW-2:0];
            n8_num[l] = (NW'(nmag[l]) << F) + NW'(r7_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_num <= n8_num;
            r8_neg <= n8_neg;
            r8_den <= rmq_pkg::DV_DEN_W'(r7_n);
        end
    end

    logic [3:0][QW-1:0] dv2_quo;
    logic [3:0]         r_neg9 [QW];

    rmq_div4 u_div_norm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_num),
        .i_den (r8_den),
        .o_quo (dv2_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg9[0] <= r8_neg;
            for (int k = 1; k < QW; k++) begin
                r_neg9[k] <= r_neg9[k-1];
            end
        end
    end

    // ---- clamp, restore sign, output register
    logic [3:0][rmq_pkg::OUT_W-1:0] n9_q, r9_q;
    logic [3:0][QW-1:0]             qcl;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            qcl[l]  = (dv2_quo[l] > QW'(rmq_pkg::OUT_LIM)) ? QW'(rmq_pkg::OUT_LIM) : dv2_quo[l];
            n9_q[l] = r_neg9[QW-1][l] ? rmq_pkg::OUT_W'(-qcl[l]) : rmq_pkg::OUT_W'(qcl[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_q <= n9_q;
        end
    end

    assign o_quat_w = r9_q[0];
    assign o_quat_x = r9_q[1];
    assign o_quat_y = r9_q[2];
    assign o_quat_z = r9_q[3];

endmodule

[tb/rmq_checker.sv]
// Checker for the matrix to quaternion core: predicts each result and compares it.
`timescale 1ns / 100ps
module rmq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [15:0] i_m00,
    input  logic [15:0] i_m01,
    input  logic [15:0] i_m02,
    input  logic [15:0] i_m10,
    input  logic [15:0] i_m11,
    input  logic [15:0] i_m12,
    input  logic [15:0] i_m20,
    input  logic [15:0] i_m21,
    input  logic [15:0] i_m22,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [15:0] o_quat_w,
    input  logic [15:0] o_quat_x,
    input  logic [15:0] o_quat_y,
    input  logic [15:0] o_quat_z,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_quat;

    t_quat quat_q[$];

    assign pending = quat_q.size();

    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > r) r++;
        return r;
    endfunction

    function automatic longint div_round(longint num, int sh, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        mag = mag << sh;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat matrix_to_quat(logic [8:0][15:0] m);
        longint a[9];
        longint cand[4];
        longint d[4];
        longint c[4];
        longint v;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned n;
        rmq_pkg::t_pick pick;
        t_quat q;
        logic [3:0][15:0] o;
        for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[i]));
        // a[] in order 00 01 02 10 11 12 20 21 22
        cand[0] = a[0] + a[4] + a[8];
        cand[1] = a[0] - a[4] - a[8];
        cand[2] = a[4] - a[0] - a[8];
        cand[3] = a[8] - a[0] - a[4];
        pick = rmq_pkg::PICK_W;
        for (int i = 1; i < 4; i++) if (cand[i] > cand[pick]) pick = rmq_pkg::t_pick'(i);
        p = root_nearest(longint'(cand[pick] + (64'sd1 << rmq_pkg::FRAC))
                         << (rmq_pkg::FRAC - 2));
        d = '{0, 0, 0, 0};
        case (pick)
            rmq_pkg::PICK_W: begin
                d[1] = a[5] - a[7]; d[2] = a[6] - a[2]; d[3] = a[1] - a[3];
            end
            rmq_pkg::PICK_X: begin
                d[0] = a[5] - a[7]; d[2] = a[1] + a[3]; d[3] = a[2] + a[6];
            end
            rmq_pkg::PICK_Y: begin
                d[0] = a[6] - a[2]; d[1] = a[1] + a[3]; d[3] = a[5] + a[7];
            end
            default: begin
                d[0] = a[1] - a[3]; d[1] = a[2] + a[6]; d[2] = a[5] + a[7];
            end
        endcase
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            c[i] = (i == pick) ? longint'(p) : div_round(d[i], rmq_pkg::FRAC, 4 * p);
            sum += longint'(c[i] * c[i]);
        end
        n = root_nearest(sum);
        for (int i = 0; i < 4; i++) begin
            v = div_round(c[i], rmq_pkg::FRAC, n);
            if (v > rmq_pkg::OUT_LIM) v = rmq_pkg::OUT_LIM;
            if (v < -rmq_pkg::OUT_LIM) v = -rmq_pkg::OUT_LIM;
            o[i] = v[15:0];
        end
        q.w = o[0]; q.x = o[1]; q.y = o[2]; q.z = o[3];
        return q;
    endfunction

    always @(posedge i_clk) begin
        t_quat want;
        t_quat got;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (i_valid && o_ready)
                quat_q.push_back(matrix_to_quat({i_m22, i_m21, i_m20, i_m12, i_m11,
                                                 i_m10, i_m02, i_m01, i_m00}));
            if (o_valid && i_ready) begin
                got = {o_quat_w, o_quat_x, o_quat_y, o_quat_z};
                if (quat_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = quat_q.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10)
                            $display("mismatch: expected w%h x%h y%h z%h, got w%h x%h y%h z%h",
                                     want.w, want.x, want.y, want.z,
                                     got.w, got.x, got.y, got.z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the matrix to quaternion core.
`timescale 1ns / 100ps
module tb_top;
    localparam int N_RANDOM  = 800;
    localparam int LAT       = 79;
    localparam int MAX_CYCLE = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [8:0][15:0] mat = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    int          fail_count;
    int          pending;
    int          cycle = 0;

    always #5 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_core DUT (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_m00(mat[0]), .i_m01(mat[1]), .i_m02(mat[2]),
        .i_m10(mat[3]), .i_m11(mat[4]), .i_m12(mat[5]),
        .i_m20(mat[6]), .i_m21(mat[7]), .i_m22(mat[8]),
        .o_valid, .i_ready, .o_quat_w, .o_quat_x, .o_quat_y, .o_quat_z
    );

    rmq_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_m00(mat[0]), .i_m01(mat[1]), .i_m02(mat[2]),
        .i_m10(mat[3]), .i_m11(mat[4]), .i_m12(mat[5]),
        .i_m20(mat[6]), .i_m21(mat[7]), .i_m22(mat[8]),
        .o_valid, .i_ready, .o_quat_w, .o_quat_x, .o_quat_y, .o_quat_z,
        .fail_count, .pending
    );

    // Receiver stall pattern: phases of steady acceptance alternate with random stalls.
    always @(posedge i_clk) begin
        int phase;
        phase = (cycle / 300) % 3;
        if (phase == 0) i_ready <= 1'b1;
        else if (phase == 1) i_ready <= ($urandom_range(0, 3) != 0);
        else i_ready <= ($urandom_range(0, 1) != 0);
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Near-rotation from a random unit quaternion, plus small noise.
    function automatic logic [8:0][15:0] rotation_matrix(int noise);
        real w, x, y, z, nrm;
        real r[9];
        logic [8:0][15:0] res;
        w = $urandom_range(0, 2000) - 1000.0;
        x = $urandom_range(0, 2000) - 1000.0;
        y = $urandom_range(0, 2000) - 1000.0;
        z = $urandom_range(0, 2000) - 1000.0;
        nrm = $sqrt(w * w + x * x + y * y + z * z) + 1.0e-9;
        w /= nrm; x /= nrm; y /= nrm; z /= nrm;
        r[0] = 1 - 2 * (y * y + z * z); r[1] = 2 * (x * y - w * z); r[2] = 2 * (x * z + w * y);
        r[3] = 2 * (x * y + w * z); r[4] = 1 - 2 * (x * x + z * z); r[5] = 2 * (y * z - w * x);
        r[6] = 2 * (x * z - w * y); r[7] = 2 * (y * z + w * x); r[8] = 1 - 2 * (x * x + y * y);
        for (int i = 0; i < 9; i++)
            res[i] = 16'($rtoi(r[i] * 16384.0) + $urandom_range(0, 2 * noise) - noise);
        return res;
    endfunction

    task automatic send_matrix(logic [8:0][15:0] m);
        mat     <= m;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [8:0][15:0] m;
        int burst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: identity, each axis half-turn, zeros, extremes, ties.
        send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384});
        send_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0,
                     16'd16384});
        send_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0,
                     -16'sd16384});
        send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0,
                     -16'sd16384});
        send_matrix('0);
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                     16'h7fff, 16'h8000});
        send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h8000, 16'h7fff});
        send_matrix({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000});
        send_matrix({16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff,
                     16'h0001, 16'hffff});
        for (int i = 0; i < 6; i++) send_matrix(rotation_matrix(0));
        // Random: mostly near-rotations, some raw noise, sent in bursts.
        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && i < N_RANDOM; b++, i++) begin
                if ($urandom_range(0, 9) < 8) m = rotation_matrix($urandom_range(0, 40));
                else for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
                send_matrix(m);
            end
            idle_gap();
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 20) @(posedge i_clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/core/rmq_pkg.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div4.sv
rtl/core/rotation_matrix_to_quaternion_core.sv
tb/rmq_checker.sv
tb/tb_top.sv
